// ----- rtl/core/slrd_pkg.sv -----
package slrd_pkg;

  // Field and internal widths.
  localparam int unsigned MIN_W      = 11;  // minute of day, window length
  localparam int unsigned HOUR_W     = 5;
  localparam int unsigned MINUTE_W   = 6;
  localparam int unsigned PCT_W      = 6;   // rise and fall share
  localparam int unsigned DUTY_W     = 7;
  localparam int unsigned PWM_OUT_W  = 12;
  localparam int unsigned LAMP_W     = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned PROD_W     = 17;  // share times length, up to 72000
  localparam int unsigned PCT100_W   = 18;  // hundred times a length
  localparam int unsigned RAMP_NUM_W = 24;  // 9500 times a length
  localparam int unsigned MCNT_W     = 3;   // counts the share bits

  // Limits and constants of the schedule.
  localparam logic [HOUR_W-1:0]     HOUR_MAX        = 5'd23;
  localparam logic [MINUTE_W-1:0]   MINUTE_MAX      = 6'd59;
  localparam logic [MIN_W-1:0]      DAY_LAST        = 11'd1439;
  localparam logic [MIN_W-1:0]      LEN_MAX         = 11'd1440;
  localparam logic [MIN_W:0]        MINUTES_PER_DAY = 12'd1440;
  localparam logic [PCT_W-1:0]      RAMP_PCT_MAX    = 6'd50;
  localparam logic [DUTY_W-1:0]     DUTY_MAX        = 7'd95;
  localparam logic [DUTY_W-1:0]     PCT_FULL        = 7'd100;
  localparam logic [RAMP_NUM_W-1:0] RAMP_SCALE      = 24'd9500;

  // Lamp state codes as seen on the result word.
  typedef enum logic [LAMP_W-1:0] {
    LAMP_OFF    = 2'd0,
    LAMP_SCHED  = 2'd1,
    LAMP_MANUAL = 2'd2
  } lamp_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIN_START  = 3'd0,
    CFG_WIN_END    = 3'd1,
    CFG_WIN_LEN    = 3'd2,
    CFG_RISE_PCT   = 3'd3,
    CFG_FALL_PCT   = 3'd4,
    CFG_MAN_MODE   = 3'd5,
    CFG_MAN_SWITCH = 3'd6
  } cfg_idx_t;

endpackage

// ----- rtl/core/scheduled_light_ramp_dimmer.sv -----
// Scheduled light ramp dimmer.
// The input channel takes one word per update tick: the hour and minute of
// the day. For each accepted word the block returns exactly one result word
// with the lamp duty in percent, the PWM compare value, power enable, the
// lamp state and a flag that marks a change of duty since the last tick.
// The configuration port writes the window, ramp shares and manual controls;
// write it only while no tick is in flight.
// A tick passes through the shift-add multiplier for the ramp shares, a
// decision state, the bit-serial divider for the ramp ratio (skipped when no
// ramp division is needed), the same divider again for the PWM compare value
// and a final state that loads the result. The next tick is taken only
// after the result is loaded, once the sequencer is back in idle.
// A finished result sits in the output register; a new tick is accepted
// while it waits, and the result stage holds the next one back until the
// receiver lowers out_stall.
// Synchronous active-low reset restores the default registers, clears the
// stored duty to zero and empties the pipeline; no clearing pass is needed.
module scheduled_light_ramp_dimmer
  import slrd_pkg::*;
#(
  parameter int unsigned PWM_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [HOUR_W-1:0]     in_clock_hour,
  input  logic [MINUTE_W-1:0]   in_clock_minute,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DUTY_W-1:0]     out_duty_percent,
  output logic [PWM_OUT_W-1:0]  out_pwm_compare,
  output logic                  out_power_enable,
  output logic [LAMP_W-1:0]     out_lamp_state,
  output logic                  out_duty_changed,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned PWM_NUM_W = DUTY_W + PWM_BITS;
  localparam int unsigned NUM_W = (PWM_NUM_W > RAMP_NUM_W) ? PWM_NUM_W : RAMP_NUM_W;
  localparam int unsigned QUO_W = (PWM_BITS > DUTY_W) ? PWM_BITS : DUTY_W;
  localparam int unsigned CNT_W = $clog2(QUO_W + 1);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_MUL    = 8'b0000_0010,
    S_DEC    = 8'b0000_0100,
    S_DSTART = 8'b0000_1000,
    S_DDIV   = 8'b0001_0000,
    S_PSTART = 8'b0010_0000,
    S_PDIV   = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_t;

  // Configuration registers.
  logic [MIN_W-1:0] win_start_r;
  logic [MIN_W-1:0] win_end_r;
  logic [MIN_W-1:0] win_len_r;
  logic [PCT_W-1:0] rise_pct_r;
  logic [PCT_W-1:0] fall_pct_r;
  logic             man_mode_r;
  logic             man_switch_r;

  // Control state.
  state_t            state_r, state_nxt;
  logic [MCNT_W-1:0] mcnt_r, mcnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DUTY_W-1:0] cur_duty_r, cur_duty_nxt;

  // Working registers.
  logic [MIN_W-1:0]     cur_r, cur_nxt;
  logic [PCT_W-1:0]     up_sr_r, up_sr_nxt;
  logic [PCT_W-1:0]     dn_sr_r, dn_sr_nxt;
  logic [PROD_W-1:0]    mcand_r, mcand_nxt;
  logic [PROD_W-1:0]    pup_r, pup_nxt;
  logic [PROD_W-1:0]    pdn_r, pdn_nxt;
  logic [MIN_W-1:0]     x_r, x_nxt;
  logic [PROD_W-1:0]    den_r, den_nxt;
  logic [DUTY_W-1:0]    duty_r, duty_nxt;
  lamp_t                lamp_r, lamp_nxt;
  logic [PWM_OUT_W-1:0] pwm_r, pwm_nxt;

  // Output word register.
  logic [DUTY_W-1:0]    o_duty_r, o_duty_nxt;
  logic [PWM_OUT_W-1:0] o_pwm_r, o_pwm_nxt;
  lamp_t                o_lamp_r, o_lamp_nxt;
  logic                 o_changed_r, o_changed_nxt;

  // Divider interface.
  logic             div_start;
  logic [NUM_W-1:0] div_num;
  logic [PROD_W-1:0] div_den;
  logic [CNT_W-1:0] div_nbits;
  logic             div_done;
  logic [QUO_W-1:0] div_quo;

  // Saturated inputs and registers.
  logic [HOUR_W-1:0]   hour_s;
  logic [MINUTE_W-1:0] minute_s;
  logic [MIN_W-1:0]    start_s, end_s, len_s;
  logic [PCT_W-1:0]    up_s, dn_s;

  // Window decision terms.
  logic                wrap;
  logic [MIN_W:0]      end_x, cur_x;
  logic                in_win;
  logic [MIN_W-1:0]    elapsed;
  logic [PCT100_W-1:0] e100, fall_thr;

  logic in_take;
  logic out_free;

  assign hour_s   = (in_clock_hour > HOUR_MAX) ? HOUR_MAX : in_clock_hour;
  assign minute_s = (in_clock_minute > MINUTE_MAX) ? MINUTE_MAX : in_clock_minute;
  assign start_s  = (win_start_r > DAY_LAST) ? DAY_LAST : win_start_r;
  assign end_s    = (win_end_r > DAY_LAST) ? DAY_LAST : win_end_r;
  assign len_s    = (win_len_r > LEN_MAX) ? LEN_MAX : win_len_r;
  assign up_s     = (rise_pct_r > RAMP_PCT_MAX) ? RAMP_PCT_MAX : rise_pct_r;
  assign dn_s     = (fall_pct_r > RAMP_PCT_MAX) ? RAMP_PCT_MAX : fall_pct_r;

  // An end below the start carries the window across midnight.
  assign wrap    = (end_s < start_s);
  assign end_x   = wrap ? ({1'b0, end_s} + MINUTES_PER_DAY) : {1'b0, end_s};
  assign cur_x   = (wrap && (cur_r < start_s)) ? ({1'b0, cur_r} + MINUTES_PER_DAY)
                                               : {1'b0, cur_r};
  assign in_win  = (cur_x >= {1'b0, start_s}) && (cur_x < end_x);
  assign elapsed = MIN_W'(cur_x - {1'b0, start_s});

  // Phase boundaries, scaled by a hundred to compare with share times length.
  assign e100     = PCT100_W'(elapsed) * PCT100_W'(PCT_FULL);
  assign fall_thr = PCT100_W'(len_s) * PCT100_W'(PCT_FULL) - PCT100_W'(pdn_r);

  assign in_take  = in_valid && (state_r == S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // Divider operands: the ramp ratio first, then the PWM scaling by 1/100.
  assign div_start = (state_r == S_DSTART) || (state_r == S_PSTART);
  always_comb begin
    if (state_r == S_PSTART) begin
      div_num   = (NUM_W'(duty_r) << PWM_BITS) - NUM_W'(duty_r);
      div_den   = PROD_W'(PCT_FULL);
      div_nbits = CNT_W'(PWM_BITS);
    end else begin
      div_num   = NUM_W'(RAMP_NUM_W'(x_r) * RAMP_SCALE);
      div_den   = den_r;
      div_nbits = CNT_W'(DUTY_W);
    end
  end

  slrd_serdiv #(
    .NUM_W (NUM_W),
    .DEN_W (PROD_W),
    .QUO_W (QUO_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .nbits (div_nbits),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Sequencer and datapath next values.
  always_comb begin
    state_nxt     = state_r;
    mcnt_nxt      = mcnt_r;
    out_valid_nxt = out_valid_r;
    cur_duty_nxt  = cur_duty_r;
    cur_nxt       = cur_r;
    up_sr_nxt     = up_sr_r;
    dn_sr_nxt     = dn_sr_r;
    mcand_nxt     = mcand_r;
    pup_nxt       = pup_r;
    pdn_nxt       = pdn_r;
    x_nxt         = x_r;
    den_nxt       = den_r;
    duty_nxt      = duty_r;
    lamp_nxt      = lamp_r;
    pwm_nxt       = pwm_r;
    o_duty_nxt    = o_duty_r;
    o_pwm_nxt     = o_pwm_r;
    o_lamp_nxt    = o_lamp_r;
    o_changed_nxt = o_changed_r;

    // The receiver takes the waiting word.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        // Minute of day and a fresh shift-add of the two ramp shares.
        if (in_take) begin
          cur_nxt   = (MIN_W'(hour_s) << 6) - (MIN_W'(hour_s) << 2) + MIN_W'(minute_s);
          up_sr_nxt = up_s;
          dn_sr_nxt = dn_s;
          mcand_nxt = PROD_W'(len_s);
          pup_nxt   = '0;
          pdn_nxt   = '0;
          mcnt_nxt  = MCNT_W'(PCT_W);
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        // One bit of each share per cycle.
        if (up_sr_r[0]) begin
          pup_nxt = pup_r + mcand_r;
        end
        if (dn_sr_r[0]) begin
          pdn_nxt = pdn_r + mcand_r;
        end
        up_sr_nxt = up_sr_r >> 1;
        dn_sr_nxt = dn_sr_r >> 1;
        mcand_nxt = mcand_r << 1;
        mcnt_nxt  = mcnt_r - MCNT_W'(1);
        if (mcnt_r == MCNT_W'(1)) begin
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        // With a non-zero length, a zero product means a zero share.
        state_nxt = S_PSTART;
        if (man_mode_r) begin
          duty_nxt = man_switch_r ? DUTY_MAX : '0;
          lamp_nxt = man_switch_r ? LAMP_MANUAL : LAMP_OFF;
        end else if (!in_win) begin
          duty_nxt = '0;
          lamp_nxt = LAMP_OFF;
        end else if (len_s == '0) begin
          duty_nxt = DUTY_MAX;
          lamp_nxt = LAMP_SCHED;
        end else if (elapsed >= len_s) begin
          duty_nxt = '0;
          lamp_nxt = LAMP_OFF;
        end else if ((pup_r != '0) && (e100 <= PCT100_W'(pup_r))) begin
          x_nxt     = elapsed;
          den_nxt   = pup_r;
          state_nxt = S_DSTART;
        end else if ((e100 <= fall_thr) || (pdn_r == '0)) begin
          duty_nxt = DUTY_MAX;
          lamp_nxt = LAMP_SCHED;
        end else begin
          x_nxt     = len_s - elapsed;
          den_nxt   = pdn_r;
          state_nxt = S_DSTART;
        end
      end
      S_DSTART: begin
        state_nxt = S_DDIV;
      end
      S_DDIV: begin
        // A ramp that rounds down to nothing leaves the lamp off.
        if (div_done) begin
          duty_nxt  = (div_quo > QUO_W'(DUTY_MAX)) ? DUTY_MAX : DUTY_W'(div_quo);
          lamp_nxt  = (div_quo != '0) ? LAMP_SCHED : LAMP_OFF;
          state_nxt = S_PSTART;
        end
      end
      S_PSTART: begin
        state_nxt = S_PDIV;
      end
      S_PDIV: begin
        if (div_done) begin
          pwm_nxt   = PWM_OUT_W'(div_quo);
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // Load the result word once the output register is free.
        if (out_free) begin
          o_duty_nxt    = duty_r;
          o_pwm_nxt     = pwm_r;
          o_lamp_nxt    = lamp_r;
          o_changed_nxt = (duty_r != cur_duty_r);
          cur_duty_nxt  = duty_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      mcnt_r       <= '0;
      out_valid_r  <= 1'b0;
      cur_duty_r   <= '0;
      win_start_r  <= 11'd480;
      win_end_r    <= 11'd1080;
      win_len_r    <= 11'd600;
      rise_pct_r   <= 6'd30;
      fall_pct_r   <= 6'd30;
      man_mode_r   <= 1'b0;
      man_switch_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mcnt_r      <= mcnt_nxt;
      out_valid_r <= out_valid_nxt;
      cur_duty_r  <= cur_duty_nxt;
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_WIN_START:  win_start_r  <= cfg_wdata[MIN_W-1:0];
          CFG_WIN_END:    win_end_r    <= cfg_wdata[MIN_W-1:0];
          CFG_WIN_LEN:    win_len_r    <= cfg_wdata[MIN_W-1:0];
          CFG_RISE_PCT:   rise_pct_r   <= cfg_wdata[PCT_W-1:0];
          CFG_FALL_PCT:   fall_pct_r   <= cfg_wdata[PCT_W-1:0];
          CFG_MAN_MODE:   man_mode_r   <= cfg_wdata[0];
          CFG_MAN_SWITCH: man_switch_r <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    up_sr_r     <= up_sr_nxt;
    dn_sr_r     <= dn_sr_nxt;
    mcand_r     <= mcand_nxt;
    pup_r       <= pup_nxt;
    pdn_r       <= pdn_nxt;
    x_r         <= x_nxt;
    den_r       <= den_nxt;
    duty_r      <= duty_nxt;
    lamp_r      <= lamp_nxt;
    pwm_r       <= pwm_nxt;
    o_duty_r    <= o_duty_nxt;
    o_pwm_r     <= o_pwm_nxt;
    o_lamp_r    <= o_lamp_nxt;
    o_changed_r <= o_changed_nxt;
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_duty_percent = o_duty_r;
  assign out_pwm_compare  = o_pwm_r;
  assign out_power_enable = (o_lamp_r != LAMP_OFF);
  assign out_lamp_state   = o_lamp_r;
  assign out_duty_changed = o_changed_r;

  // The divider only finishes while the sequencer waits for it.
  a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> ((state_r == S_DDIV) || (state_r == S_PDIV)))
    else $error("divider finished outside a divide state");

  // An accepted tick always starts the share multiplication.
  a_take_starts_mul: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> (state_r == S_MUL))
    else $error("accepted tick did not start the multiplier");

  // A waiting word is never overwritten by the next result.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(o_duty_r)
                                    && $stable(o_pwm_r)))
    else $error("pending result word was overwritten");

endmodule

// ----- rtl/core/slrd_serdiv.sv -----
// Restoring divider that produces one quotient bit per cycle, most significant
// first. The divisor is pre-shifted by nbits-1 and walks right one place per
// cycle; the caller guarantees that the quotient fits in nbits.
module slrd_serdiv #(
  parameter int unsigned NUM_W = 24,
  parameter int unsigned DEN_W = 17,
  parameter int unsigned QUO_W = 12,
  parameter int unsigned CNT_W = $clog2(QUO_W + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic [CNT_W-1:0] nbits,
  output logic             done,
  output logic [QUO_W-1:0] quo
);

  localparam int unsigned SH_W  = DEN_W + QUO_W - 1;
  localparam int unsigned CMP_W = (SH_W > NUM_W) ? SH_W : NUM_W;

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] rem_r;
  logic [SH_W-1:0]  dsr_r;
  logic [QUO_W-1:0] quo_r;

  logic [CMP_W-1:0] rem_ext;
  logic [CMP_W-1:0] dsr_ext;
  logic [CMP_W-1:0] diff;
  logic             take;

  // One trial subtraction of the shifted divisor.
  assign rem_ext = CMP_W'(rem_r);
  assign dsr_ext = CMP_W'(dsr_r);
  assign diff    = rem_ext - dsr_ext;
  assign take    = (rem_ext >= dsr_ext);

  // Control: busy while bits remain, a one-cycle done after the last bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= nbits;
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder, walking divisor and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      dsr_r <= SH_W'(den) << (nbits - CNT_W'(1));
      quo_r <= '0;
    end else if (busy_r) begin
      if (take) begin
        rem_r <= NUM_W'(diff);
      end
      dsr_r <= dsr_r >> 1;
      quo_r <= {quo_r[QUO_W-2:0], take};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ----- dv/tb.sv -----
module tb;
  import slrd_pkg::*;

  localparam int unsigned PWM_BITS         = 12;
  localparam int unsigned PWM_FULL_SCALE   = (1 << PWM_BITS) - 1;
  localparam int unsigned MINUTES_PER_HOUR = 60;
  localparam int unsigned HALF_PERIOD      = 5;
  localparam int unsigned RESET_CYCLES     = 6;
  localparam int unsigned SETTLE_CYCLES    = 40;  // quiet time after the last owed word
  localparam int unsigned HOLD_CYCLES      = 400;
  localparam int unsigned PHASES           = 10;
  localparam int unsigned TICKS_PER_PHASE  = 48;
  localparam int unsigned CYCLE_LIMIT      = 1000000;

  // One result word as the lamp controller should present it.
  typedef struct {
    logic [DUTY_W-1:0]    duty;
    logic [PWM_OUT_W-1:0] pwm;
    logic                 power;
    lamp_t                lamp;
    logic                 changed;
  } lamp_word_t;

  // Scoreboard: a shadow of the registers and the stored duty, plus the
  // words still owed by the block in order of acceptance.
  class dimmer_scoreboard;
    lamp_word_t        words_due[$];
    int unsigned       errors;
    logic [MIN_W-1:0]  win_start, win_end, win_len;
    logic [PCT_W-1:0]  rise_share, fall_share;
    logic              manual_on_mode, manual_switch;
    logic [DUTY_W-1:0] last_duty;

    function new();
      errors         = 0;
      win_start      = 11'd480;
      win_end        = 11'd1080;
      win_len        = 11'd600;
      rise_share     = 6'd30;
      fall_share     = 6'd30;
      manual_on_mode = 1'b0;
      manual_switch  = 1'b0;
      last_duty      = '0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_WIN_START:  win_start      = value[MIN_W-1:0];
        CFG_WIN_END:    win_end        = value[MIN_W-1:0];
        CFG_WIN_LEN:    win_len        = value[MIN_W-1:0];
        CFG_RISE_PCT:   rise_share     = value[PCT_W-1:0];
        CFG_FALL_PCT:   fall_share     = value[PCT_W-1:0];
        CFG_MAN_MODE:   manual_on_mode = value[0];
        CFG_MAN_SWITCH: manual_switch  = value[0];
        default: ;
      endcase
    endfunction

    // Trapezoid: rise, hold at the cap, then fall, all in integer steps.
    function int unsigned ramp_percent(int unsigned e, int unsigned d,
                                       int unsigned up, int unsigned down);
      if (d == 0) return DUTY_MAX;
      if (e >= d) return 0;
      if (up != 0 && PCT_FULL * e <= up * d) return (RAMP_SCALE * e) / (up * d);
      if (PCT_FULL * e <= (PCT_FULL - down) * d || down == 0) return DUTY_MAX;
      return (RAMP_SCALE * (d - e)) / (down * d);
    endfunction

    // Work out the word that an accepted tick must produce.
    function void note_tick(logic [HOUR_W-1:0] hour, logic [MINUTE_W-1:0] minute);
      int unsigned hr, mn, now, st, en, d, up, down, t, duty;
      lamp_t       lamp;
      lamp_word_t  w;
      hr   = (hour > HOUR_MAX) ? HOUR_MAX : hour;
      mn   = (minute > MINUTE_MAX) ? MINUTE_MAX : minute;
      duty = 0;
      lamp = LAMP_OFF;
      if (manual_on_mode) begin
        if (manual_switch) begin
          duty = DUTY_MAX;
          lamp = LAMP_MANUAL;
        end
      end else begin
        now = hr * MINUTES_PER_HOUR + mn;
        st  = (win_start > DAY_LAST) ? DAY_LAST : win_start;
        en  = (win_end > DAY_LAST) ? DAY_LAST : win_end;
        // An end before the start runs on past midnight.
        if (en < st) begin
          en += MINUTES_PER_DAY;
          if (now < st) now += MINUTES_PER_DAY;
        end
        if (now >= st && now < en) begin
          d    = (win_len > LEN_MAX) ? LEN_MAX : win_len;
          up   = (rise_share > RAMP_PCT_MAX) ? RAMP_PCT_MAX : rise_share;
          down = (fall_share > RAMP_PCT_MAX) ? RAMP_PCT_MAX : fall_share;
          t    = ramp_percent(now - st, d, up, down);
          if (t > 0) begin
            duty = (t > DUTY_MAX) ? DUTY_MAX : t;
            lamp = LAMP_SCHED;
          end
        end
      end
      w.duty    = DUTY_W'(duty);
      w.pwm     = PWM_OUT_W'((duty * PWM_FULL_SCALE) / PCT_FULL);
      w.power   = (lamp != LAMP_OFF);
      w.lamp    = lamp;
      w.changed = (DUTY_W'(duty) != last_duty);
      last_duty = DUTY_W'(duty);
      words_due.push_back(w);
    endfunction

    function void compare_field(string label, int unsigned want, logic [15:0] got);
      if (got !== 16'(want)) begin
        errors++;
        $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
      end
    endfunction

    // Compare a result word with the oldest word owed.
    function void check_word(logic [DUTY_W-1:0] duty, logic [PWM_OUT_W-1:0] pwm,
                             logic power, logic [LAMP_W-1:0] lamp, logic changed);
      lamp_word_t want;
      if (words_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, expected none, got duty %0d state %0d",
                 $time, duty, lamp);
        return;
      end
      want = words_due.pop_front();
      compare_field("duty_percent", want.duty, duty);
      compare_field("pwm_compare", want.pwm, pwm);
      compare_field("power_enable", want.power, power);
      compare_field("lamp_state", want.lamp, lamp);
      compare_field("duty_changed", want.changed, changed);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [HOUR_W-1:0]     in_clock_hour = '0;
  logic [MINUTE_W-1:0]   in_clock_minute = '0;
  logic                  out_valid;
  logic                  out_stall;
  logic [DUTY_W-1:0]     out_duty_percent;
  logic [PWM_OUT_W-1:0]  out_pwm_compare;
  logic                  out_power_enable;
  logic [LAMP_W-1:0]     out_lamp_state;
  logic                  out_duty_changed;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_WIN_START;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  dimmer_scoreboard sb = new();
  bit               no_idle = 1'b0;
  bit               hold_off = 1'b0;
  int unsigned      cycles = 0;

  scheduled_light_ramp_dimmer #(.PWM_BITS(PWM_BITS)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_clock_hour    (in_clock_hour),
    .in_clock_minute  (in_clock_minute),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_duty_percent (out_duty_percent),
    .out_pwm_compare  (out_pwm_compare),
    .out_power_enable (out_power_enable),
    .out_lamp_state   (out_lamp_state),
    .out_duty_changed (out_duty_changed),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #HALF_PERIOD clk = ~clk;

  // Watch both channels at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_tick(in_clock_hour, in_clock_minute);
      if (out_valid && !out_stall) begin
        sb.check_word(out_duty_percent, out_pwm_compare, out_power_enable,
                      out_lamp_state, out_duty_changed);
      end
    end
  end

  // Give up if the run hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: random stalls, and one long hold-off when asked for.
  initial begin : result_sink
    int unsigned n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off  = 1'b0;
        out_stall = 1'b0;
      end else if (no_idle || $urandom_range(0, 3) != 0) begin
        out_stall = 1'b0;
      end else begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
        out_stall = 1'b1;
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  // Offer one tick word after a random gap and hold it until taken.
  task automatic send_tick(input logic [HOUR_W-1:0] hour, input logic [MINUTE_W-1:0] minute);
    int unsigned gap;
    gap = 0;
    if (!no_idle) begin
      case ($urandom_range(0, 9))
        0:       gap = $urandom_range(10, 60);
        1, 2, 3: gap = $urandom_range(1, 3);
        default: gap = 0;
      endcase
    end
    if (gap != 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid        = 1'b1;
    in_clock_hour   = hour;
    in_clock_minute = minute;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop offering and wait until every owed word has come back.
  task automatic drain_results(input int unsigned extra);
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.words_due.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.write_reg(idx, value);
  endtask

  // Reprogram every register once the block has gone quiet.
  task automatic apply_setting(input logic [CFG_DATA_W-1:0] st, en, len, rise, fall,
                               input logic [CFG_DATA_W-1:0] mode, switch_on);
    drain_results(SETTLE_CYCLES);
    write_reg(CFG_WIN_START, st);
    write_reg(CFG_WIN_END, en);
    write_reg(CFG_WIN_LEN, len);
    write_reg(CFG_RISE_PCT, rise);
    write_reg(CFG_FALL_PCT, fall);
    write_reg(CFG_MAN_MODE, mode);
    write_reg(CFG_MAN_SWITCH, switch_on);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_minute();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return DAY_LAST;
      2:       return CFG_DATA_W'($urandom_range(1440, 2047));
      default: return CFG_DATA_W'($urandom_range(0, 1439));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_share();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return RAMP_PCT_MAX;
      2:       return {5'($urandom), 6'($urandom_range(51, 63))};
      default: return CFG_DATA_W'($urandom_range(0, 50));
    endcase
  endfunction

  // Stimulus: directed cases first, then random settings with random ticks.
  initial begin : stimulus
    int unsigned           ph, k, st, en, dur, tod;
    logic [CFG_DATA_W-1:0] s_w, e_w, l_w, r_w, f_w, mm_w, ms_w;
    logic [HOUR_W-1:0]     hour;
    logic [MINUTE_W-1:0]   minute;
    bit                    raw_time;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    // Default window 08:00 to 18:00: before, rising, holding, falling, after,
    // and times that must saturate.
    send_tick(5'd0, 6'd0);
    send_tick(5'd8, 6'd0);
    send_tick(5'd9, 6'd0);
    send_tick(5'd11, 6'd0);
    send_tick(5'd13, 6'd0);
    send_tick(5'd17, 6'd59);
    send_tick(5'd18, 6'd0);
    send_tick(5'd31, 6'd63);
    send_tick(5'd24, 6'd30);

    // Overnight window with no rise and the widest fall.
    apply_setting(11'd1320, 11'd120, 11'd240, 11'd0, 11'd50, 11'd0, 11'd0);
    send_tick(5'd23, 6'd0);
    send_tick(5'd1, 6'd30);
    send_tick(5'd21, 6'd59);
    send_tick(5'd2, 6'd0);

    // Zero length gives full duty; shares beyond the limit saturate.
    apply_setting(11'd0, DAY_LAST, 11'd0, 11'd63, 11'd63, 11'd0, 11'd0);
    send_tick(5'd12, 6'd0);
    send_tick(5'd0, 6'd0);

    // Start and end saturate to the same minute, so the window is empty.
    apply_setting(11'd2047, 11'd1500, 11'd2047, 11'd0, 11'd0, 11'd0, 11'd0);
    send_tick(5'd23, 6'd59);

    // Length shorter than the window: off once it has run out.
    apply_setting(11'd0, DAY_LAST, 11'd60, 11'd0, 11'd0, 11'd0, 11'd0);
    send_tick(5'd0, 6'd30);
    send_tick(5'd2, 6'd0);

    // Manual override, switch on then off.
    apply_setting(11'd600, 11'd600, 11'd600, 11'd30, 11'd30, 11'd1, 11'd1);
    send_tick(5'd5, 6'd5);
    send_tick(5'd31, 6'd63);
    apply_setting(11'd600, 11'd600, 11'd600, 11'd30, 11'd30, 11'd1, 11'd0);
    send_tick(5'd5, 6'd6);

    // Thinnest ramps over a whole day.
    apply_setting(11'd0, DAY_LAST, LEN_MAX, 11'd1, 11'd1, 11'd0, 11'd0);
    send_tick(5'd0, 6'd14);
    send_tick(5'd23, 6'd50);

    // Random settings, each followed by a run of ticks.
    tod = 0;
    for (ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) begin
        s_w = '0;  e_w = DAY_LAST;  l_w = LEN_MAX;
        r_w = RAMP_PCT_MAX;  f_w = RAMP_PCT_MAX;  mm_w = '0;  ms_w = '0;
      end else begin
        s_w = pick_minute();
        e_w = ($urandom_range(0, 9) == 0) ? s_w : pick_minute();
        st  = (s_w > DAY_LAST) ? DAY_LAST : s_w;
        en  = (e_w > DAY_LAST) ? DAY_LAST : e_w;
        dur = (en + MINUTES_PER_DAY - st) % MINUTES_PER_DAY;
        case ($urandom_range(0, 19))
          0, 1:                l_w = '0;
          2:                   l_w = LEN_MAX;
          3:                   l_w = CFG_DATA_W'($urandom_range(1441, 2047));
          4, 5, 6, 7, 8, 9:    l_w = CFG_DATA_W'($urandom_range(1, 1440));
          default:             l_w = (dur == 0) ? CFG_DATA_W'(1) : CFG_DATA_W'(dur);
        endcase
        r_w  = pick_share();
        f_w  = pick_share();
        mm_w = {10'($urandom), ($urandom_range(0, 4) == 0)};
        ms_w = {10'($urandom), 1'($urandom)};
      end
      apply_setting(s_w, e_w, l_w, r_w, f_w, mm_w, ms_w);
      st  = (s_w > DAY_LAST) ? DAY_LAST : s_w;
      en  = (e_w > DAY_LAST) ? DAY_LAST : e_w;
      dur = (en + MINUTES_PER_DAY - st) % MINUTES_PER_DAY;

      // Two phases run flat out, and the second also starves the receiver a while.
      no_idle = (ph == 2 || ph == 4);
      if (ph == 4) hold_off = 1'b1;

      for (k = 0; k < TICKS_PER_PHASE; k++) begin
        if (ph == 6 && k == TICKS_PER_PHASE / 2) drain_results(0);
        raw_time = 1'b0;
        case ($urandom_range(0, 9))
          0: begin
            hour     = HOUR_W'($urandom_range(0, 31));
            minute   = MINUTE_W'($urandom_range(0, 63));
            raw_time = 1'b1;
          end
          1, 2, 3: tod = (tod + $urandom_range(0, 1)) % MINUTES_PER_DAY;
          4, 5, 6, 7: tod = (st + $urandom_range(0, dur + 2)) % MINUTES_PER_DAY;
          default: tod = $urandom_range(0, 1439);
        endcase
        // Raw times may lie outside the day and must saturate in the block.
        if (!raw_time) begin
          hour   = HOUR_W'(tod / MINUTES_PER_HOUR);
          minute = MINUTE_W'(tod % MINUTES_PER_HOUR);
        end
        send_tick(hour, minute);
      end
      no_idle = 1'b0;
    end

    drain_results(SETTLE_CYCLES);
    if (sb.errors == 0 && sb.words_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
